>>> src/longest_word_chain_dag_defines.svh
// Assertion macros for the longest word chain block.
// Used by the top level only; no other dependencies.
`ifndef LONGEST_WORD_CHAIN_DAG_DEFINES_SVH
`define LONGEST_WORD_CHAIN_DAG_DEFINES_SVH
// implication check under reset
`define LWC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwc check failed");
// next-cycle implication check under reset
`define LWC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lwc check failed");
`endif

>>> src/lwc_pkg.sv
// Shared constants and types for the longest word chain block.
// No dependencies.
`timescale 1ns / 1ps
package lwc_pkg;
  localparam int MaxWords = 64;
  localparam int IdxW = $clog2(MaxWords);
  localparam int CntW = $clog2(MaxWords + 1);
  localparam int LetW = 5;

  typedef struct packed {
    logic [LetW-1:0] first_letter;
    logic [LetW-1:0] final_letter;
    logic            last_word;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] word_index;
    logic [CntW-1:0] chain_length;
    logic            has_cycle;
    logic            too_many;
    logic            last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DEG_CLR, OP_DEG_ACC, OP_FIND, OP_BEST,
    OP_REMOVE, OP_TOP, OP_WALK, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic            first;
  } cmd_t;

  typedef struct packed {
    logic            link;
    logic            zero_deg;
    logic [CntW-1:0] count;
    logic            too;
    logic [CntW-1:0] top_len;
    logic [IdxW-1:0] top_idx;
    logic [IdxW-1:0] cur;
  } sts_t;
endpackage

>>> src/lwc_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on no package; payload type is a type parameter.
`timescale 1ns / 1ps
interface lwc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/lwc_datapath.sv
// Datapath: letter stores, degree, length and predecessor stores, chain buffer.
// Depends on lwc_pkg.
`timescale 1ns / 1ps
module lwc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lwc_pkg::cmd_t     cmd,
  input  lwc_pkg::in_item_t in_item,
  output lwc_pkg::sts_t     sts,
  output logic [lwc_pkg::IdxW-1:0] emit_idx
);
  import lwc_pkg::*;

  logic [LetW-1:0] start_mem [MaxWords];
  logic [LetW-1:0] end_mem   [MaxWords];
  logic [CntW-1:0] deg_mem   [MaxWords];
  logic            rem_mem   [MaxWords];
  logic [CntW-1:0] best_mem  [MaxWords];
  logic [IdxW-1:0] pred_mem  [MaxWords];
  logic [IdxW-1:0] chain_mem [MaxWords];

  cmd_t            cmd_d_r;
  logic [LetW-1:0] end_i_r, start_j_r;
  logic [CntW-1:0] deg_i_r, deg_j_r, best_i_r;
  logic            rem_i_r, rem_j_r;
  logic [IdxW-1:0] pred_cur_r, chain_j_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic            too_r;
  logic [CntW-1:0] acc_r, bestv_r, top_len_r;
  logic [IdxW-1:0] pred_r, top_idx_r, cur_r;
  logic            link;
  logic [CntW-1:0] cand;

  // operations run in the cycle after their command, on registered store reads
  assign link = (cmd_d_r.i != cmd_d_r.j) && (end_i_r == start_j_r);
  assign cand = best_i_r + CntW'(1);
  assign count_nxt = count_r + CntW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      too_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      if (count_r == CntW'(MaxWords)) too_r <= 1'b1;
      else count_r <= count_nxt;
    end else if (cmd.op == OP_EMIT && cmd.first) begin
      count_r <= '0;
      too_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && count_r != CntW'(MaxWords)) begin
      start_mem[count_r[IdxW-1:0]] <= in_item.first_letter;
      end_mem[count_r[IdxW-1:0]] <= in_item.final_letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cmd_d_r <= '{op: OP_NONE, i: '0, j: '0, first: 1'b0};
    else cmd_d_r <= cmd;
  end

  always_ff @(posedge clk) begin
    end_i_r <= end_mem[cmd.i];
    start_j_r <= start_mem[cmd.j];
    deg_i_r <= deg_mem[cmd.i];
    deg_j_r <= deg_mem[cmd.j];
    rem_i_r <= rem_mem[cmd.i];
    rem_j_r <= rem_mem[cmd.j];
    best_i_r <= best_mem[cmd.i];
    pred_cur_r <= pred_mem[cur_r];
    chain_j_r <= chain_mem[cmd.j];
  end

  always_ff @(posedge clk) begin
    unique case (cmd_d_r.op)
      OP_DEG_CLR: acc_r <= '0;
      OP_DEG_ACC: begin
        if (link) begin
          if (cmd_d_r.first) acc_r <= CntW'(1);
          else acc_r <= acc_r + CntW'(1);
        end else if (cmd_d_r.first) acc_r <= '0;
      end
      OP_FIND: begin
        deg_mem[cmd_d_r.j] <= acc_r;
        rem_mem[cmd_d_r.j] <= 1'b0;
      end
      OP_BEST: begin
        if (cmd_d_r.first) begin
          bestv_r <= CntW'(1);
          pred_r <= cmd_d_r.j;
        end else if (link && cand >= bestv_r) begin
          bestv_r <= cand;
          pred_r <= cmd_d_r.i;
        end
      end
      OP_REMOVE: begin
        if (cmd_d_r.first) begin
          best_mem[cmd_d_r.i] <= bestv_r;
          pred_mem[cmd_d_r.i] <= pred_r;
          rem_mem[cmd_d_r.i] <= 1'b1;
        end else if (!rem_j_r && link && deg_j_r != '0) begin
          deg_mem[cmd_d_r.j] <= deg_j_r - CntW'(1);
        end
      end
      OP_TOP: begin
        if (cmd_d_r.first) begin
          top_len_r <= CntW'(1);
          top_idx_r <= '0;
        end else if (best_i_r > top_len_r) begin
          top_len_r <= best_i_r;
          top_idx_r <= cmd_d_r.i;
        end
      end
      OP_WALK: begin
        if (cmd_d_r.first) cur_r <= top_idx_r;
        else begin
          chain_mem[cmd_d_r.j] <= cur_r;
          cur_r <= pred_cur_r;
        end
      end
      default: ;
    endcase
  end

  assign sts.link = link;
  assign sts.zero_deg = !rem_i_r && deg_i_r == '0;
  assign sts.count = count_r;
  assign sts.too = too_r;
  assign sts.top_len = top_len_r;
  assign sts.top_idx = top_idx_r;
  assign sts.cur = cur_r;
  assign emit_idx = chain_j_r;
endmodule

>>> src/lwc_ctrl.sv
// Controller: load, degree count, Kahn/DP sweeps, chain walk, result emit.
// Depends on lwc_pkg.
`timescale 1ns / 1ps
module lwc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  input  lwc_pkg::sts_t      sts,
  input  logic [lwc_pkg::IdxW-1:0] emit_idx,
  output lwc_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output lwc_pkg::out_item_t out_item
);
  import lwc_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_DEG, S_DEGW, S_FIND, S_BEST, S_REM, S_TOP, S_WALK, S_WLEN, S_FETCH,
    S_EMIT, S_OUT
  } state_t;

  state_t          state_r;
  logic [IdxW-1:0] i_r, j_r;
  logic            first_r;
  logic            ph_r;
  logic [CntW-1:0] n_r, done_r, k_r, len_r;
  logic            too_r, cyc_r, ov_r;
  out_item_t       ob_r;
  logic            lastw_r;
  logic [IdxW-1:0] nm1;

  assign nm1 = IdxW'(n_r - CntW'(1));
  assign in_ready = (state_r == S_LOAD) && !ov_r;

  always_comb begin
    cmd = '{op: OP_NONE, i: i_r, j: j_r, first: first_r};
    unique case (state_r)
      S_LOAD: cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
      S_DEG: cmd.op = OP_DEG_ACC;
      S_DEGW: cmd.op = OP_FIND;
      S_FIND: cmd.op = OP_NONE;
      S_BEST: cmd.op = OP_BEST;
      S_REM: cmd.op = OP_REMOVE;
      S_TOP: cmd.op = OP_TOP;
      S_WALK: cmd.op = (first_r || !ph_r) ? OP_WALK : OP_NONE;
      S_WLEN: cmd.op = OP_NONE;
      S_FETCH: cmd.op = OP_NONE;
      S_EMIT: cmd.op = OP_NONE;
      S_OUT: cmd.op = (out_ready && lastw_r) ? OP_EMIT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
    if (state_r == S_OUT) cmd.first = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      first_r <= 1'b0;
      ph_r <= 1'b0;
      ov_r <= 1'b0;
      out_valid <= 1'b0;
      lastw_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: if (in_valid && in_ready && in_last) begin
          n_r <= (sts.count == CntW'(MaxWords)) ? sts.count : sts.count + CntW'(1);
          too_r <= sts.too || sts.count == CntW'(MaxWords);
          i_r <= '0; j_r <= '0; first_r <= 1'b1;
          state_r <= S_DEG;
        end
        S_DEG: begin
          first_r <= 1'b0;
          if (i_r == nm1) state_r <= S_DEGW;
          else i_r <= i_r + IdxW'(1);
        end
        S_DEGW: begin
          i_r <= '0; first_r <= 1'b1;
          if (j_r == nm1) begin
            j_r <= '0; done_r <= '0;
            state_r <= S_FIND;
          end else begin
            j_r <= j_r + IdxW'(1);
            state_r <= S_DEG;
          end
        end
        S_FIND: begin
          // first cycle lets the last store write settle, then address and check
          if (first_r) first_r <= 1'b0;
          else if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r <= 1'b0;
            if (sts.zero_deg) begin
              j_r <= i_r; first_r <= 1'b1;
              state_r <= S_BEST;
            end else if (i_r == nm1) begin
              cyc_r <= 1'b1; state_r <= S_EMIT;
            end else i_r <= i_r + IdxW'(1);
          end
        end
        S_BEST: begin
          // i_r sweeps sources, j_r holds the chosen word
          if (first_r) begin
            first_r <= 1'b0; i_r <= '0;
          end else if (i_r == nm1) begin
            i_r <= j_r; j_r <= '0; first_r <= 1'b1;
            state_r <= S_REM;
          end else i_r <= i_r + IdxW'(1);
        end
        S_REM: begin
          if (first_r) first_r <= 1'b0;
          else if (j_r == nm1) begin
            i_r <= '0;
            first_r <= 1'b1;
            if (done_r + CntW'(1) == n_r) begin
              state_r <= S_TOP;
            end else begin
              done_r <= done_r + CntW'(1); state_r <= S_FIND;
            end
          end else j_r <= j_r + IdxW'(1);
        end
        S_TOP: begin
          if (first_r) begin
            first_r <= 1'b0; i_r <= '0;
          end else if (i_r == nm1) begin
            first_r <= 1'b1; state_r <= S_WALK;
          end else i_r <= i_r + IdxW'(1);
        end
        S_WALK: begin
          // each predecessor step alternates a walk command with a wait for the registered read
          if (first_r) begin
            first_r <= 1'b0; state_r <= S_WLEN;
          end else if (!ph_r) ph_r <= 1'b1;
          else begin
            ph_r <= 1'b0;
            if (j_r == '0) begin
              cyc_r <= 1'b0; k_r <= '0; state_r <= S_FETCH;
            end else j_r <= j_r - IdxW'(1);
          end
        end
        S_WLEN: begin
          len_r <= sts.top_len;
          j_r <= IdxW'(sts.top_len - CntW'(1));
          ph_r <= 1'b0;
          state_r <= S_WALK;
        end
        S_FETCH: state_r <= S_EMIT;
        S_EMIT: begin
          ob_r.word_index <= cyc_r ? '0 : emit_idx;
          ob_r.chain_length <= cyc_r ? '0 : len_r;
          ob_r.has_cycle <= cyc_r;
          ob_r.too_many <= too_r;
          ob_r.last_result <= cyc_r || (k_r + CntW'(1) == len_r);
          lastw_r <= cyc_r || (k_r + CntW'(1) == len_r);
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (lastw_r) state_r <= S_LOAD;
          else begin
            k_r <= k_r + CntW'(1);
            j_r <= j_r + IdxW'(1);
            state_r <= S_FETCH;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_item = ob_r;
endmodule

>>> src/longest_word_chain_dag.sv
// Top level of the longest word chain block: controller plus datapath.
// Depends on lwc_pkg, lwc_if, lwc_ctrl, lwc_datapath and the defines header.
//
//   channel | dir | payload
//   in      | in  | first_letter, final_letter, last_word
//   out     | out | word_index, chain_length, has_cycle, too_many, last_result
//
// Words are taken back to back while loading. The final word starts degree
// counting, then per word a zero in-degree scan, a best/pred sweep and a
// removal sweep, all through the single link comparator with registered store
// reads, then the chain walk. Results leave one at a time, each fetched after
// the previous one is taken.
// Synchronous reset clears control only; stalls on out hold the result.
`timescale 1ns / 1ps
`include "longest_word_chain_dag_defines.svh"
module longest_word_chain_dag (
  input logic clk,
  input logic rst_n,
  lwc_if.sink   in_ch,
  lwc_if.source out_ch
);
  import lwc_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic [IdxW-1:0] emit_idx;

  lwc_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_ch.data),
    .sts(sts), .emit_idx(emit_idx)
  );

  lwc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_last(in_ch.data.last_word), .sts(sts), .emit_idx(emit_idx), .cmd(cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.data)
  );

  `LWC_ASSERT_IMP(a_no_overlap, in_ch.ready, !out_ch.valid)
  `LWC_ASSERT_IMP(a_cycle_len, out_ch.valid && out_ch.data.has_cycle,
      out_ch.data.chain_length == '0 && out_ch.data.last_result)
  `LWC_ASSERT_NXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.data.last_result,
      in_ch.ready)
endmodule

>>> test/tb_longest_word_chain_dag.sv
// Testbench for longest_word_chain_dag: directed and random word sets through the in channel,
// with chain results checked against a built-in longest-path predictor.
// Depends on lwc_pkg, lwc_if and the longest_word_chain_dag RTL.
`timescale 1ns / 1ps
module tb_longest_word_chain_dag;
  import lwc_pkg::*;

  localparam int StallLimit = 100000;

  typedef struct {
    in_item_t word;
    bit       hold_off;
  } word_req_t;

  logic clk;
  logic rst_n;

  lwc_if #(.payload_t(in_item_t))  in_ch  (.clk(clk));
  lwc_if #(.payload_t(out_item_t)) out_ch (.clk(clk));

  longest_word_chain_dag DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  word_req_t word_q[$];
  out_item_t chain_q[$];
  int        errors;
  int        idle_cycles;
  bit        word_taken;
  int        send_gap;
  int        recv_gap;

  logic [LetW-1:0] first_mem[MaxWords];
  logic [LetW-1:0] final_mem[MaxWords];
  int              words_held;
  bit              dropped;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit joins(int src, int dst);
    return src != dst && final_mem[src] == first_mem[dst];
  endfunction

  // Kahn elimination with the longest-path update, then chain backtrack.
  task automatic chain_predict(in_item_t w);
    int        n, done, pick, best, pred, top, len, cur;
    int        indeg[MaxWords];
    bit        gone[MaxWords];
    int        span[MaxWords];
    int        back[MaxWords];
    int        path[MaxWords];
    bit        looped;
    out_item_t r;
    if (words_held < MaxWords) begin
      first_mem[words_held] = w.first_letter;
      final_mem[words_held] = w.final_letter;
      words_held++;
    end else begin
      dropped = 1'b1;
    end
    if (!w.last_word) return;
    n = words_held;
    looped = 1'b0;
    for (int j = 0; j < n; j++) begin
      indeg[j] = 0;
      gone[j] = 1'b0;
      for (int i = 0; i < n; i++) if (joins(i, j)) indeg[j]++;
    end
    done = 0;
    while (done < n && !looped) begin
      pick = n;
      for (int i = 0; i < n; i++) begin
        if (!gone[i] && indeg[i] == 0) begin
          pick = i;
          break;
        end
      end
      if (pick == n) begin
        looped = 1'b1;
      end else begin
        best = 1;
        pred = pick;
        for (int j = 0; j < n; j++) begin
          if (joins(j, pick) && span[j] + 1 >= best) begin
            best = span[j] + 1;
            pred = j;
          end
        end
        span[pick] = best;
        back[pick] = pred;
        gone[pick] = 1'b1;
        done++;
        for (int j = 0; j < n; j++)
          if (!gone[j] && joins(pick, j) && indeg[j] > 0) indeg[j]--;
      end
    end
    r = '0;
    r.too_many = dropped;
    if (looped) begin
      r.has_cycle = 1'b1;
      r.last_result = 1'b1;
      chain_q.push_back(r);
    end else begin
      best = 1;
      top = 0;
      for (int i = 0; i < n; i++) begin
        if (span[i] > best) begin
          best = span[i];
          top = i;
        end
      end
      len = best;
      cur = top;
      for (int i = len; i > 0; i--) begin
        path[i-1] = cur;
        cur = back[cur];
      end
      for (int i = 0; i < len; i++) begin
        r.word_index = IdxW'(path[i]);
        r.chain_length = CntW'(len);
        r.last_result = (i == len - 1);
        chain_q.push_back(r);
      end
    end
    words_held = 0;
    dropped = 1'b0;
  endtask

  // flavor 0: any 5-bit letters; 1: ascending letters, no cycles; 2: tiny alphabet
  task automatic queue_set(int n, int flavor, bit hold_first);
    word_req_t q;
    int        a, b;
    for (int k = 0; k < n; k++) begin
      case (flavor)
        0: begin
          a = $urandom_range(0, 31);
          b = $urandom_range(0, 31);
        end
        1: begin
          a = $urandom_range(0, 24);
          b = $urandom_range(a + 1, (a + 6 > 25) ? 25 : a + 6);
        end
        default: begin
          a = $urandom_range(0, 3);
          b = $urandom_range(0, 3);
        end
      endcase
      q.word.first_letter = LetW'(a);
      q.word.final_letter = LetW'(b);
      q.word.last_word = (k == n - 1);
      q.hold_off = hold_first && k == 0;
      word_q.push_back(q);
    end
  endtask

  task automatic queue_word(int a, int b, bit last);
    word_req_t q;
    q.word.first_letter = LetW'(a);
    q.word.final_letter = LetW'(b);
    q.word.last_word = last;
    q.hold_off = 1'b0;
    word_q.push_back(q);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && !word_taken) begin
        in_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (word_q.size() > 0 && (!word_q[0].hold_off || chain_q.size() == 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= word_q[0].word;
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
    word_taken = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        word_taken = 1'b1;
        idle_cycles = 0;
        chain_predict(in_ch.data);
        void'(word_q.pop_front());
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (chain_q.size() == 0) begin
          $error("unexpected result word_index=%0d", out_ch.data.word_index);
          errors++;
        end else begin
          if (out_ch.data.word_index !== chain_q[0].word_index) begin
            $error("word_index expected %0d got %0d", chain_q[0].word_index,
                   out_ch.data.word_index);
            errors++;
          end
          if (out_ch.data.chain_length !== chain_q[0].chain_length) begin
            $error("chain_length expected %0d got %0d", chain_q[0].chain_length,
                   out_ch.data.chain_length);
            errors++;
          end
          if (out_ch.data.has_cycle !== chain_q[0].has_cycle) begin
            $error("has_cycle expected %0d got %0d", chain_q[0].has_cycle,
                   out_ch.data.has_cycle);
            errors++;
          end
          if (out_ch.data.too_many !== chain_q[0].too_many) begin
            $error("too_many expected %0d got %0d", chain_q[0].too_many,
                   out_ch.data.too_many);
            errors++;
          end
          if (out_ch.data.last_result !== chain_q[0].last_result) begin
            $error("last_result expected %0d got %0d", chain_q[0].last_result,
                   out_ch.data.last_result);
            errors++;
          end
          void'(chain_q.pop_front());
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("tb_longest_word_chain_dag: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    word_taken = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    words_held = 0;
    dropped = 1'b0;

    // directed sets
    queue_word(0, 0, 1'b1);
    queue_word(31, 31, 1'b1);
    queue_word(1, 2, 1'b0);
    queue_word(2, 1, 1'b1);
    queue_word(0, 1, 1'b0);
    queue_word(1, 2, 1'b0);
    queue_word(2, 3, 1'b1);
    queue_word(3, 3, 1'b0);
    queue_word(3, 4, 1'b1);
    queue_word(25, 0, 1'b0);
    queue_word(0, 25, 1'b1);
    queue_word(5, 9, 1'b0);
    queue_word(9, 30, 1'b0);
    queue_word(5, 9, 1'b0);
    queue_word(30, 16, 1'b1);
    queue_set(64, 1, 1'b1);
    queue_set(66, 1, 1'b1);
    while (word_q.size() < 400) queue_set($urandom_range(1, 10), $urandom_range(0, 2), 1'b0);
    queue_set(3, 1, 1'b1);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (word_q.size() == 0 && chain_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && chain_q.size() == 0) begin
      $display("tb_longest_word_chain_dag: clean");
    end else begin
      $display("tb_longest_word_chain_dag: errors");
    end
    $finish;
  end
endmodule
